// ===== hw/rtl/scta_pkg.sv =====
// package for the scancode to ascii decoder: command types, scancode codes, key tables
`default_nettype none

package scta_pkg;

  // operation carried from the front end to the ring back end
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       shift;
  } cmd_t;

  // request types
  localparam logic REQ_SCANCODE = 1'b0;
  localparam logic REQ_READ     = 1'b1;

  // modifier scancodes
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam int         BREAK_BIT       = 7;

  // key table size
  localparam int         MAP_LEN     = 59;
  localparam logic [7:0] MAP_LEN_B   = 8'(MAP_LEN);
  localparam int         MAP_IDX_W   = $clog2(MAP_LEN);

  // letter ranges and case offset
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  // us layout, no shift
  localparam logic [7:0] PLAIN_MAP [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  // us layout, shift held
  localparam logic [7:0] SHIFTED_MAP [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  // table lookup with shift selection, then caps flips letter case only
  function automatic logic [7:0] decode_char(input logic [7:0] code, input logic shift,
                                             input logic caps);
    logic [7:0] ch;
    logic [MAP_IDX_W-1:0] idx;
    idx = code[MAP_IDX_W-1:0];
    if (code >= MAP_LEN_B) begin
      ch = 8'h00;
    end else if (shift) begin
      ch = SHIFTED_MAP[idx];
    end else begin
      ch = PLAIN_MAP[idx];
    end
    if (caps) begin
      if (ch >= LOWER_A && ch <= LOWER_Z) begin
        ch = ch - CASE_DELTA;
      end else if (ch >= UPPER_A && ch <= UPPER_Z) begin
        ch = ch + CASE_DELTA;
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scta_in_if.sv =====
// request channel: scancode or read request with valid/ready handshake
`default_nettype none

interface scta_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] scancode;

  modport source (output valid, output req_type, output scancode, input ready);
  modport sink   (input valid, input req_type, input scancode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scta_out_if.sv =====
// result channel: popped character and status flags with valid/ready handshake
`default_nettype none

interface scta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic       queue_nonempty;
  logic       shift_held;
  logic       dropped;

  modport source (output valid, output char_out, output char_valid, output queue_nonempty,
                  output shift_held, output dropped, input ready);
  modport sink   (input valid, input char_out, input char_valid, input queue_nonempty,
                  input shift_held, input dropped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scta_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scta_front.sv =====
// front end: tracks shift and caps, classifies each request into a ring command
`default_nettype none

module scta_front (
  input  wire logic          clk,
  input  wire logic          rst,
  scta_in_if.sink            in_ch,
  output scta_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import scta_pkg::*;

  logic shift;
  logic shift_next;
  logic caps;
  logic caps_next;
  logic accept;
  logic [7:0] ch;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid & cmd_ready;

  // classify the request and work out modifier updates
  always_comb begin
    shift_next = shift;
    caps_next  = caps;
    ch         = decode_char(in_ch.scancode, shift, caps);
    cmd.op     = OP_NONE;
    cmd.ch     = ch;
    if (in_ch.req_type == REQ_READ) begin
      cmd.op = OP_READ;
    end else if (in_ch.scancode == SC_LSHIFT_MAKE || in_ch.scancode == SC_RSHIFT_MAKE) begin
      shift_next = 1'b1;
    end else if (in_ch.scancode == SC_LSHIFT_BREAK || in_ch.scancode == SC_RSHIFT_BREAK) begin
      shift_next = 1'b0;
    end else if (in_ch.scancode == SC_CAPS_MAKE) begin
      caps_next = ~caps;
    end else if (!in_ch.scancode[BREAK_BIT] && ch != 8'h00) begin
      cmd.op = OP_PUSH;
    end
    cmd.shift = shift_next;
  end

  // modifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= 1'b0;
      caps  <= 1'b0;
    end else if (accept) begin
      shift <= shift_next;
      caps  <= caps_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scta_cmd_fifo.sv =====
// two entry command queue between the front end and the ring back end
`default_nettype none

module scta_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scta_pkg::cmd_t  push_cmd,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output scta_pkg::cmd_t       pop_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);
  import scta_pkg::*;

  cmd_t       slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_idx];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_idx] <= push_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_idx <= ~wr_idx;
      end
      if (do_pop) begin
        rd_idx <= ~rd_idx;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scta_back.sv =====
// back end: character ring pointers, ram access and the result register
`default_nettype none

module scta_back #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scta_pkg::cmd_t  cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  scta_out_if.source           out_ch
);
  import scta_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] rd_inc;
  logic             empty;
  logic             full;
  logic             fire;
  logic             do_pop;
  logic             do_push;
  logic             do_drop;
  logic [7:0]       rdata;

  // middle stage, waits on ram read data
  logic s1_valid;
  logic s1_pop;
  logic s1_nonempty;
  logic s1_shift;
  logic s1_dropped;
  logic s1_adv;
  logic s1_free;
  logic out_free;

  // output register
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_nonempty;
  logic       out_shift;
  logic       out_dropped;

  // handshake flow through the two stages
  assign out_free  = ~out_valid | out_ch.ready;
  assign s1_adv    = s1_valid & out_free;
  assign s1_free   = ~s1_valid | s1_adv;
  assign cmd_ready = s1_free;
  assign fire      = cmd_valid & s1_free;

  // ring occupancy and pointer updates
  always_comb begin
    wr_inc      = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
    rd_inc      = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    empty       = (wr_ptr == rd_ptr);
    full        = (wr_inc == rd_ptr);
    do_pop      = fire & (cmd.op == OP_READ) & ~empty;
    do_push     = fire & (cmd.op == OP_PUSH) & ~full;
    do_drop     = fire & (cmd.op == OP_PUSH) & full;
    wr_ptr_next = do_push ? wr_inc : wr_ptr;
    rd_ptr_next = do_pop ? rd_inc : rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  scta_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr),
    .wdata (cmd.ch),
    .re    (do_pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_pop      <= do_pop;
      s1_nonempty <= (wr_ptr_next != rd_ptr_next);
      s1_shift    <= cmd.shift;
      s1_dropped  <= do_drop;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_char       <= s1_pop ? rdata : 8'h00;
      out_char_valid <= s1_pop;
      out_nonempty   <= s1_nonempty;
      out_shift      <= s1_shift;
      out_dropped    <= s1_dropped;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.char_out       = out_char;
  assign out_ch.char_valid     = out_char_valid;
  assign out_ch.queue_nonempty = out_nonempty;
  assign out_ch.shift_held     = out_shift;
  assign out_ch.dropped        = out_dropped;

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_to_ascii_fifo.sv =====
// path: an accepted request passes the command queue, the middle stage and the output register
// throughput: one transaction per cycle unless the result channel stalls, supported by the ring
// pointer update and the ram with separate write and read ports
// reset: synchronous, clears shift, caps, ring pointers and the command queue;
// the ring ram is not cleared, a pop only reads slots written earlier
`default_nettype none

module scancode_to_ascii_fifo #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  scta_in_if.sink   in_ch,
  scta_out_if.source out_ch
);
  import scta_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  scta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  scta_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  scta_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
